/* rtl/dmsc_pkg.sv */
// Package for the delta-modulation sample channel: payload types, codes and rate tables.
package dmsc_pkg;

  // Item kinds carried by req_type.
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_DELIVER = 2'd2;

  // Register selectors carried by reg_sel.
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_LEVEL   = 3'd1;
  localparam logic [2:0] REG_START   = 3'd2;
  localparam logic [2:0] REG_LENGTH  = 3'd3;
  localparam logic [2:0] REG_ENABLE  = 3'd4;

  // Address, level and bit-count constants.
  localparam logic [15:0] ADDR_START_BASE = 16'hC000;
  localparam logic [15:0] ADDR_WRAP       = 16'h8000;
  localparam logic [6:0]  LEVEL_UP_MAX    = 7'd125;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  // Timer reload values, one less than each period of the rate tables.
  localparam logic [8:0] RELOAD_NTSC [16] = '{
    9'd427, 9'd379, 9'd339, 9'd319, 9'd285, 9'd253, 9'd225, 9'd213,
    9'd189, 9'd159, 9'd141, 9'd127, 9'd105, 9'd83,  9'd71,  9'd53
  };
  localparam logic [8:0] RELOAD_PAL [16] = '{
    9'd397, 9'd353, 9'd315, 9'd297, 9'd275, 9'd235, 9'd209, 9'd197,
    9'd175, 9'd147, 9'd131, 9'd117, 9'd97,  9'd77,  9'd65,  9'd49
  };
  localparam logic [8:0] RELOAD_MAX = 9'd427;

  // One input item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_sel;
    logic [7:0] data_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [6:0]  level_out;
    logic        fetch_request;
    logic [15:0] fetch_addr;
    logic        irq;
    logic        active;
  } out_item_t;

endpackage

/* rtl/delta_modulation_sample_channel.sv */
// Top level of the delta-modulation sample channel.
//
//   Channel   Handshake            Payload
//   in        in_valid/in_stall    in_data   (in_item_t)
//   out       out_valid/out_stall  out_data  (out_item_t)
//   config    cfg_we               cfg_data  (pal_timing)
//
// An item passes from input transfer into the input register, then through
// the state update into the result register.
// One item is accepted every cycle while the output side keeps taking results.
// A stall on the output holds the result register and, through it, the
// input register; the input stalls only while both are full.
// Reset (rst, synchronous) empties both registers and loads the channel state.
module delta_modulation_sample_channel
  import dmsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  // Input register and pipeline control.
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;
  logic     in_xfer;

  // Channel state.
  logic        pal_timing;
  logic        chan_enabled, chan_enabled_next;
  logic        irq_enabled, irq_enabled_next;
  logic        loop_mode, loop_mode_next;
  logic [3:0]  rate_index, rate_index_next;
  logic [6:0]  level, level_next;
  logic [15:0] start_addr, start_addr_next;
  logic [11:0] length_load, length_load_next;
  logic [15:0] current_addr, current_addr_next;
  logic [11:0] remaining, remaining_next;
  logic [7:0]  buffer_byte, buffer_byte_next;
  logic        buffer_full, buffer_full_next;
  logic [7:0]  shifter, shifter_next;
  logic [3:0]  bits_remaining, bits_remaining_next;
  logic        silent, silent_next;
  logic [8:0]  rate_timer, rate_timer_next;
  logic        pending_fetch, pending_fetch_next;
  logic        irq_latched, irq_latched_next;

  logic [8:0]  reload;
  logic [15:0] addr_inc;
  logic [11:0] remaining_dec;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Timer reload for the selected table and rate.
  assign reload = pal_timing ? RELOAD_PAL[rate_index] : RELOAD_NTSC[rate_index];

  assign addr_inc      = current_addr + 16'd1;
  assign remaining_dec = remaining - 12'd1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_xfer) begin
      s1_item <= in_data;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_timing <= 1'b0;
    end else if (cfg_we) begin
      pal_timing <= cfg_data;
    end
  end

  // State update for the item in the input register.
  always_comb begin
    chan_enabled_next   = chan_enabled;
    irq_enabled_next    = irq_enabled;
    loop_mode_next      = loop_mode;
    rate_index_next     = rate_index;
    level_next          = level;
    start_addr_next     = start_addr;
    length_load_next    = length_load;
    current_addr_next   = current_addr;
    remaining_next      = remaining;
    buffer_byte_next    = buffer_byte;
    buffer_full_next    = buffer_full;
    shifter_next        = shifter;
    bits_remaining_next = bits_remaining;
    silent_next         = silent;
    rate_timer_next     = rate_timer;
    pending_fetch_next  = pending_fetch;
    irq_latched_next    = irq_latched;

    unique case (s1_item.req_type)
      REQ_TICK: begin
        // An idle channel does not run its timer.
        if (chan_enabled || remaining != '0 || buffer_full || pending_fetch) begin
          if (rate_timer != '0) begin
            rate_timer_next = rate_timer - 9'd1;
          end else begin
            rate_timer_next = reload;
            // Start of a new output byte: reload the shifter or go silent.
            if (bits_remaining == '0) begin
              bits_remaining_next = BITS_PER_BYTE;
              if (buffer_full) begin
                shifter_next     = buffer_byte;
                buffer_full_next = 1'b0;
                silent_next      = 1'b0;
              end else begin
                silent_next = 1'b1;
              end
              if (chan_enabled && remaining != '0) begin
                pending_fetch_next = 1'b1;
              end
            end
            // Move the level by two, saturating at both ends.
            if (!silent_next) begin
              if (shifter_next[0]) begin
                if (level <= LEVEL_UP_MAX) begin
                  level_next = level + 7'd2;
                end
              end else if (level >= 7'd2) begin
                level_next = level - 7'd2;
              end
            end
            shifter_next        = {1'b0, shifter_next[7:1]};
            bits_remaining_next = bits_remaining_next - 4'd1;
          end
        end
      end
      REQ_WRITE: begin
        unique case (s1_item.reg_sel)
          REG_CONTROL: begin
            irq_enabled_next = s1_item.data_byte[7];
            loop_mode_next   = s1_item.data_byte[6];
            rate_index_next  = s1_item.data_byte[3:0];
            if (!s1_item.data_byte[7]) begin
              irq_latched_next = 1'b0;
            end
          end
          REG_LEVEL: begin
            level_next = s1_item.data_byte[6:0];
          end
          REG_START: begin
            start_addr_next = ADDR_START_BASE | {2'b00, s1_item.data_byte, 6'b000000};
          end
          REG_LENGTH: begin
            length_load_next = {s1_item.data_byte, 4'b0001};
          end
          REG_ENABLE: begin
            irq_latched_next  = 1'b0;
            chan_enabled_next = s1_item.data_byte[4];
            if (!s1_item.data_byte[4]) begin
              remaining_next     = '0;
              pending_fetch_next = 1'b0;
            end else if (remaining == '0) begin
              // Restart the sample; the length is never zero.
              rate_timer_next     = reload;
              bits_remaining_next = '0;
              silent_next         = 1'b1;
              current_addr_next   = start_addr;
              remaining_next      = length_load;
              if (!buffer_full) begin
                pending_fetch_next = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      REQ_DELIVER: begin
        // Bytes arriving without a pending request are ignored; stale ones dropped.
        if (pending_fetch) begin
          pending_fetch_next = 1'b0;
          if (chan_enabled && remaining != '0 && !buffer_full) begin
            buffer_byte_next  = s1_item.data_byte;
            buffer_full_next  = 1'b1;
            current_addr_next = (addr_inc == '0) ? ADDR_WRAP : addr_inc;
            remaining_next    = remaining_dec;
            if (remaining_dec == '0) begin
              if (loop_mode) begin
                current_addr_next = start_addr;
                remaining_next    = length_load;
              end else if (irq_enabled) begin
                irq_latched_next = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Channel state registers, updated as each item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_enabled   <= 1'b0;
      irq_enabled    <= 1'b0;
      loop_mode      <= 1'b0;
      rate_index     <= '0;
      level          <= '0;
      start_addr     <= ADDR_START_BASE;
      length_load    <= 12'd1;
      current_addr   <= ADDR_START_BASE;
      remaining      <= '0;
      buffer_byte    <= '0;
      buffer_full    <= 1'b0;
      shifter        <= '0;
      bits_remaining <= '0;
      silent         <= 1'b1;
      rate_timer     <= '0;
      pending_fetch  <= 1'b0;
      irq_latched    <= 1'b0;
    end else if (advance) begin
      chan_enabled   <= chan_enabled_next;
      irq_enabled    <= irq_enabled_next;
      loop_mode      <= loop_mode_next;
      rate_index     <= rate_index_next;
      level          <= level_next;
      start_addr     <= start_addr_next;
      length_load    <= length_load_next;
      current_addr   <= current_addr_next;
      remaining      <= remaining_next;
      buffer_byte    <= buffer_byte_next;
      buffer_full    <= buffer_full_next;
      shifter        <= shifter_next;
      bits_remaining <= bits_remaining_next;
      silent         <= silent_next;
      rate_timer     <= rate_timer_next;
      pending_fetch  <= pending_fetch_next;
      irq_latched    <= irq_latched_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data.level_out     <= level_next;
      out_data.fetch_request <= pending_fetch_next;
      out_data.fetch_addr    <= current_addr_next;
      out_data.irq           <= irq_latched_next;
      out_data.active        <= (remaining_next != '0);
    end
  end

  // A processed item always lands in the result register.
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("result register not loaded after an item was processed");

  // A taken result with nothing behind it leaves the result register empty.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !advance) |=> !out_valid)
    else $error("result repeated after its transfer");

  // A fetch is only ever pending on an enabled channel.
  assert property (@(posedge clk) disable iff (rst) pending_fetch |-> chan_enabled)
    else $error("fetch pending on a disabled channel");

  // Sample addresses stay in the upper half of the address space.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fetch_addr[15])
    else $error("fetch address below the sample region");

  // The rate timer never exceeds the longest reload.
  assert property (@(posedge clk) disable iff (rst) rate_timer <= RELOAD_MAX)
    else $error("rate timer out of range");

endmodule
